>>> hw/rtl/sdmm_pkg.sv
// ----------------------------------------------------------------------------
// sdmm_pkg
// Shared types and constants for the sparse-dense matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none
package sdmm_pkg;
	localparam int MaxClasses  = 16;
	localparam int MaxFeatures = 1024;
	localparam int MaxSamples  = 1024;
	localparam int ClsW  = 4;
	localparam int FeatW = 10;
	localparam int SampW = 10;
	localparam int AccW  = 40;
	localparam int WAddrW = ClsW + FeatW;
	localparam int AAddrW = ClsW + SampW;
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;

	typedef enum logic [1:0] {
		MODE_WEIGHT = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_NZ     = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [ClsW-1:0]    cls;
		logic [FeatW-1:0]   feat;
		logic [SampW-1:0]   samp;
		logic signed [15:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RUN
	} state_t;

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
endpackage
`default_nettype wire

>>> hw/rtl/sdmm_ram.sv
// ----------------------------------------------------------------------------
// sdmm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sdmm_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/sdmm_front.sv
// ----------------------------------------------------------------------------
// sdmm_front
// Command intake: screens out-of-range items and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module sdmm_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sdmm_pkg::cmd_t cmd_in,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output sdmm_pkg::cmd_t      cmd_out
);
	sdmm_pkg::cmd_t             q_q [sdmm_pkg::QDepth];
	logic [sdmm_pkg::QPtrW-1:0] wp_q, rp_q;
	logic [sdmm_pkg::QPtrW:0]   cnt_q;
	logic                       keep;

	// indices are full-range at default sizes; weight/nonzero bounds always hold
	always_comb begin
		keep = 1'b1;
		if (cmd_in.mode == sdmm_pkg::MODE_WEIGHT &&
		    (32'(cmd_in.cls) >= sdmm_pkg::MaxClasses ||
		     32'(cmd_in.feat) >= sdmm_pkg::MaxFeatures)) keep = 1'b0;
		if (cmd_in.mode == sdmm_pkg::MODE_NZ &&
		    (32'(cmd_in.feat) >= sdmm_pkg::MaxFeatures ||
		     32'(cmd_in.samp) >= sdmm_pkg::MaxSamples)) keep = 1'b0;
	end

	logic do_push;
	assign do_push = push && keep;
	assign full    = cnt_q == (sdmm_pkg::QPtrW+1)'(sdmm_pkg::QDepth);
	assign empty   = cnt_q == '0;
	assign cmd_out = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) q_q[wp_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (sdmm_pkg::QPtrW+1)'(do_push) - (sdmm_pkg::QPtrW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/sdmm_back.sv
// ----------------------------------------------------------------------------
// sdmm_back
// Execution engine: one class row per cycle through a 3-stage MAC/read pipe.
// ----------------------------------------------------------------------------
`default_nettype none
module sdmm_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [4:0]                   num_classes,
	input  wire logic                         empty,
	input  wire sdmm_pkg::cmd_t               cmd,
	output logic                              pop,
	output logic                              busy_pipe,
	output logic                              strobe,
	output logic [sdmm_pkg::ClsW-1:0]         out_class,
	output logic signed [sdmm_pkg::AccW-1:0]  out_value,
	output logic                              last
);
	localparam int CW = sdmm_pkg::ClsW;
	localparam int AW = sdmm_pkg::AccW;

	sdmm_pkg::state_t state_q, state_d;
	sdmm_pkg::cmd_t   cur_q;
	logic [CW-1:0]    row_q;
	logic [sdmm_pkg::AAddrW-1:0] clr_q;
	logic [CW-1:0]    rows_m1;
	logic [CW:0]      nc_lim;
	logic             row_last;
	logic             clr_last;
	logic             clearing;

	always_comb begin
		nc_lim = num_classes;
		if (nc_lim == '0) nc_lim = (CW+1)'(1);
		if (32'(nc_lim) > sdmm_pkg::MaxClasses) nc_lim = (CW+1)'(sdmm_pkg::MaxClasses);
		rows_m1 = CW'(nc_lim - 1'b1);
	end
	assign row_last = row_q == rows_m1;
	assign clr_last = clr_q == '1;

	logic v_s1, v_s2, v_s3;
	logic rd_s1, rd_s2, rd_s3, lst_s1, lst_s2, lst_s3;
	logic [CW-1:0] c_s1, c_s2, c_s3;
	logic [sdmm_pkg::SampW-1:0] sp_s1, sp_s2;
	logic signed [15:0] d_s1;
	logic signed [31:0] prod_s2;
	logic signed [AW-1:0] ard_s2;
	logic signed [AW-1:0] acc_s3;

	logic [sdmm_pkg::WAddrW-1:0] wraddr;
	logic [sdmm_pkg::AAddrW-1:0] araddr, awaddr;
	logic signed [15:0] wrd;
	logic [AW-1:0] ard;
	logic wwe, awe;
	logic acc_we;
	logic [sdmm_pkg::AAddrW-1:0] acc_waddr;
	logic [AW-1:0] acc_wdata;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdmm_pkg::ST_IDLE: begin
				if (!empty && cmd.mode == sdmm_pkg::MODE_CLEAR) state_d = sdmm_pkg::ST_CLEAR;
				else if (!empty && (cmd.mode == sdmm_pkg::MODE_NZ ||
				         cmd.mode == sdmm_pkg::MODE_READ)) state_d = sdmm_pkg::ST_RUN;
			end
			sdmm_pkg::ST_CLEAR: if (clr_last) state_d = sdmm_pkg::ST_IDLE;
			sdmm_pkg::ST_RUN: if (row_last) state_d = sdmm_pkg::ST_IDLE;
			default: state_d = sdmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		clearing = state_q == sdmm_pkg::ST_CLEAR;
		wwe      = 1'b0;
		unique case (state_q)
			sdmm_pkg::ST_IDLE: if (!empty) begin
				pop = 1'b1;
				wwe = cmd.mode == sdmm_pkg::MODE_WEIGHT;
			end
			default: ;
		endcase
	end

	// a queued nonzero may read an accumulator still being updated: stall
	logic hazard;
	assign hazard = v_s1 || v_s2 || v_s3;
	assign busy_pipe = state_q != sdmm_pkg::ST_IDLE || hazard;

	assign wraddr = {row_q, cur_q.feat};
	assign araddr = {row_q, cur_q.samp};

	// clear pass owns the write port; the pipe is empty whenever it runs
	assign acc_we    = awe || clearing;
	assign acc_waddr = clearing ? clr_q : awaddr;
	assign acc_wdata = clearing ? '0 : acc_s3;

	sdmm_ram #(.Width(16), .Depth(sdmm_pkg::MaxClasses * sdmm_pkg::MaxFeatures)) u_w (
		.clk(clk), .we(wwe), .waddr({cmd.cls, cmd.feat}), .wdata(cmd.data),
		.raddr(wraddr), .rdata(wrd)
	);
	sdmm_ram #(.Width(AW), .Depth(sdmm_pkg::MaxClasses * sdmm_pkg::MaxSamples)) u_a (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(araddr), .rdata(ard)
	);

	logic signed [AW:0] sum;
	always_comb begin
		sum = {ard_s2[AW-1], ard_s2} + (AW+1)'(prod_s2);
	end

	always_ff @(posedge clk) begin
		c_s1 <= row_q; sp_s1 <= cur_q.samp; d_s1 <= cur_q.data; rd_s1 <= cur_q.mode == sdmm_pkg::MODE_READ;
		lst_s1 <= row_last;
		c_s2 <= c_s1; sp_s2 <= sp_s1; rd_s2 <= rd_s1; lst_s2 <= lst_s1;
		ard_s2 <= ard;
		prod_s2 <= rd_s1 ? 32'sd0 : wrd * d_s1;
		c_s3 <= c_s2; rd_s3 <= rd_s2; lst_s3 <= lst_s2;
		awaddr <= {c_s2, sp_s2};
		if (sum > (AW+1)'(sdmm_pkg::AccMax)) acc_s3 <= sdmm_pkg::AccMax;
		else if (sum < (AW+1)'(sdmm_pkg::AccMin)) acc_s3 <= sdmm_pkg::AccMin;
		else acc_s3 <= AW'(sum);
	end
	assign awe = v_s3 && !rd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdmm_pkg::ST_CLEAR;
			row_q   <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			v_s1 <= state_q == sdmm_pkg::ST_RUN;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (state_q == sdmm_pkg::ST_RUN) row_q <= row_last ? '0 : row_q + 1'b1;
			if (clearing) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= cmd;
	end

	assign strobe    = v_s3 && rd_s3;
	assign out_class = c_s3;
	assign out_value = acc_s3;
	assign last      = lst_s3;
endmodule
`default_nettype wire

>>> hw/rtl/sparse_dense_matmul_core.sv
// ----------------------------------------------------------------------------
// sparse_dense_matmul_core
// W (class x feature) times sparse X, Q3.12 in, saturating Q15.24 out.
// ----------------------------------------------------------------------------
// Transactions enter a four-deep command queue, so start is taken while the
// engine works; busy is high only while the queue is full. The engine retires
// transactions in order: a weight write is a single RAM write, a nonzero makes
// one multiply-accumulate per class row on the single MAC and accumulator RAM
// port, a read makes one accumulator read per class row, and the pipe drains
// before the next transaction is taken; a clear zeroes all 16384 accumulators
// one per cycle. The same clear pass runs after reset. A read emits its
// num_classes results (clamped to 1..16) on consecutive strobe cycles, class 0
// first, last on the final one; results cannot be stalled.
`default_nettype none
module sparse_dense_matmul_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         mode,
	input  wire logic [3:0]         class_index,
	input  wire logic [9:0]         feature_index,
	input  wire logic [9:0]         sample_index,
	input  wire logic signed [15:0] data_value,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata,
	output logic                    strobe,
	output logic [3:0]              out_class,
	output logic signed [39:0]      out_value,
	output logic                    last
);
	logic [4:0] nc_q;
	sdmm_pkg::cmd_t cin, cq;
	logic full, empty, pop, bp, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nc_q <= 5'd16;
		else if (cfg_we) nc_q <= cfg_wdata;
	end

	assign cin  = '{mode: sdmm_pkg::mode_t'(mode), cls: class_index, feat: feature_index,
	                samp: sample_index, data: data_value};
	assign busy = full;
	assign push = start && !busy;

	sdmm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .cmd_in(cin), .full(full),
		.pop(pop), .empty(empty), .cmd_out(cq)
	);

	logic qe;
	assign qe = empty || bp;

	sdmm_back u_back (
		.clk(clk), .arst_n(arst_n), .num_classes(nc_q), .empty(qe), .cmd(cq),
		.pop(pop), .busy_pipe(bp), .strobe(strobe),
		.out_class(out_class), .out_value(out_value), .last(last)
	);
endmodule
`default_nettype wire

>>> hw/rtl/sdmm_checker.sv
// ----------------------------------------------------------------------------
// sdmm_checker
// Port-level checks for the matmul core.
// ----------------------------------------------------------------------------
`default_nettype none
module sdmm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       strobe,
	input wire logic [3:0] out_class,
	input wire logic       last
);
	a_class_seq: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && out_class == $past(out_class) + 4'd1)
		else $error("class sequence broken");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe || out_class == 4'd0)
		else $error("run does not start at class 0");
	a_start0: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> out_class == 4'd0)
		else $error("run does not start at class 0");
endmodule

bind sparse_dense_matmul_core sdmm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .strobe(strobe), .out_class(out_class), .last(last)
);
`default_nettype wire
